// ===== rtl/core/msom_pkg.sv =====
`default_nettype none

package msom_pkg;

  localparam int MaxMotif    = 32;
  localparam int ReadLenMax  = 65536;
  localparam int HitLimitMax = 15;

  localparam int MotifW  = 2 * MaxMotif;
  localparam int RunW    = $clog2(MaxMotif + 1);
  localparam int IndexW  = $clog2(ReadLenMax + 1);
  localparam int PosW    = 16;
  localparam int LimitW  = 4;
  localparam int LenW    = 6;

  localparam logic [1:0] KIND_EXACT    = 2'd0;
  localparam logic [1:0] KIND_ONE_MISS = 2'd1;
  localparam logic [1:0] KIND_SUMMARY  = 2'd2;

  localparam logic [1:0] REG_MOTIF_CODE = 2'd0;
  localparam logic [1:0] REG_MOTIF_LEN  = 2'd1;
  localparam logic [1:0] REG_HIT_LIMIT  = 2'd2;

  localparam int OutDataW = 24;

  typedef struct packed {
    logic              last;
    logic              too_long;
    logic              limit_reached;
    logic [LimitW-1:0] hit_total;
    logic [PosW-1:0]   position;
    logic [1:0]        kind;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] code;
  } base_t;

  function automatic base_t decode_base(input logic [7:0] ch);
    base_t b;
    b.valid = 1'b1;
    b.code  = 2'd0;
    case (ch)
      8'h41, 8'h61: b.code = 2'd0;
      8'h43, 8'h63: b.code = 2'd1;
      8'h47, 8'h67: b.code = 2'd2;
      8'h54, 8'h74: b.code = 2'd3;
      default: b.valid = 1'b0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/motif_scan_one_mismatch_core.sv =====
// motif scanner, hamming distance at most one
// input stream: one read character per word on s_tdata, s_tlast on the final
// character of a read. acgt in either case are bases, anything else empties
// the base window. each window of motif_len bases that equals the motif or
// differs in one base gives a hit word (kind, start position); the word
// after the last character of a read is a summary (hit_total, limit_reached,
// too_long). m_tlast marks the last output word caused by one input word.
// throughput: one character per cycle while s_tready is high. the compare,
// window shift and counters settle in the accept cycle and the words go to
// a four-entry output queue. s_tready is high while the queue has room for
// two words, so a receiver stall backs up into s_tready after three or four
// words are waiting. reset clears the queue and per-read state and sets
// motif_code 0, motif_len 22, hit_limit 3. registers are written over the
// apb port at byte addresses 0, 8 and 16; the user must write them only
// while the stream is idle, as the block itself does not enforce this.
`default_nettype none

module motif_scan_one_mismatch_core (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire  [7:0]                   s_tdata,   // base_char
  input  wire                          s_tlast,
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [msom_pkg::OutDataW-1:0] m_tdata,  // kind, position, hit_total,
                                                  // limit_reached, too_long
  output logic                         m_tlast,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [4:0]                   paddr,
  input  wire  [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);
  import msom_pkg::*;

  localparam int QDepth = 4;
  localparam int QPtrW  = 2;
  localparam int QCntW  = 3;

  logic [MotifW-1:0] motif_code;
  logic [LenW-1:0]   motif_len;
  logic [LimitW-1:0] hit_limit;

  logic [MotifW-1:0] window;
  logic [RunW-1:0]   valid_run;
  logic [IndexW-1:0] char_index;
  logic [LimitW-1:0] hits_seen;
  logic              overflowed;

  result_t           queue [QDepth];
  logic [QPtrW-1:0]  wr_ptr;
  logic [QPtrW-1:0]  rd_ptr;
  logic [QCntW-1:0]  count;

  logic              cfg_wr;
  logic [LenW-1:0]   len_eff;
  logic [LimitW-1:0] lim_eff;
  logic              take;
  logic              pop;
  base_t             base;
  logic              in_range;
  logic [MotifW-1:0] window_next;
  logic [RunW-1:0]   valid_run_next;
  logic [MaxMotif-1:0] miss;
  logic              hit;
  logic [LimitW-1:0] hits_next;
  logic              overflowed_next;
  logic [PosW-1:0]   start_pos;
  result_t           hit_word;
  result_t           sum_word;
  logic [QCntW-1:0]  n_push;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      motif_code <= '0;
      motif_len  <= LenW'(22);
      hit_limit  <= LimitW'(3);
    end else if (cfg_wr) begin
      case (paddr[4:3])
        REG_MOTIF_CODE: motif_code <= pwdata;
        REG_MOTIF_LEN:  motif_len  <= pwdata[LenW-1:0];
        REG_HIT_LIMIT:  hit_limit  <= pwdata[LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[4:3])
      REG_MOTIF_CODE: prdata = motif_code;
      REG_MOTIF_LEN:  prdata = {{(64-LenW){1'b0}}, motif_len};
      REG_HIT_LIMIT:  prdata = {{(64-LimitW){1'b0}}, hit_limit};
      default:        prdata = '0;
    endcase
  end

  // effective settings
  always_comb begin
    if (motif_len == '0) begin
      len_eff = LenW'(1);
    end else if (motif_len > LenW'(MaxMotif)) begin
      len_eff = LenW'(MaxMotif);
    end else begin
      len_eff = motif_len;
    end
    if (hit_limit == '0) begin
      lim_eff = LimitW'(1);
    end else if (hit_limit > LimitW'(HitLimitMax)) begin
      lim_eff = LimitW'(HitLimitMax);
    end else begin
      lim_eff = hit_limit;
    end
  end

  // scan logic
  assign s_tready = (count <= QCntW'(QDepth - 2));
  assign take     = s_tvalid & s_tready;
  assign pop      = m_tvalid & m_tready;
  assign base     = decode_base(s_tdata);
  assign in_range = (char_index < IndexW'(ReadLenMax));

  always_comb begin
    if (base.valid) begin
      window_next    = {window[MotifW-3:0], base.code};
      valid_run_next = (valid_run < RunW'(MaxMotif)) ? valid_run + RunW'(1) : valid_run;
    end else begin
      window_next    = '0;
      valid_run_next = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < MaxMotif; i++) begin
      miss[i] = (window_next[2*i +: 2] != motif_code[2*i +: 2]) && (i < int'(len_eff));
    end
  end

  assign hit = base.valid && (valid_run_next >= RunW'(len_eff)) && in_range
               && (hits_seen < lim_eff) && ((miss & (miss - MaxMotif'(1))) == '0);

  assign hits_next       = hit ? hits_seen + LimitW'(1) : hits_seen;
  assign overflowed_next = overflowed | ~in_range;
  assign start_pos       = char_index[PosW-1:0] - PosW'(len_eff) + PosW'(1);

  always_comb begin
    hit_word               = '0;
    hit_word.kind          = (miss == '0) ? KIND_EXACT : KIND_ONE_MISS;
    hit_word.position      = start_pos;
    hit_word.last          = ~s_tlast;
    sum_word               = '0;
    sum_word.kind          = KIND_SUMMARY;
    sum_word.hit_total     = hits_next;
    sum_word.limit_reached = (hits_next >= lim_eff);
    sum_word.too_long      = overflowed_next;
    sum_word.last          = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= '0;
      valid_run  <= '0;
      char_index <= '0;
      hits_seen  <= '0;
      overflowed <= 1'b0;
    end else if (take) begin
      if (s_tlast) begin
        window     <= '0;
        valid_run  <= '0;
        char_index <= '0;
        hits_seen  <= '0;
        overflowed <= 1'b0;
      end else begin
        window     <= window_next;
        valid_run  <= valid_run_next;
        char_index <= in_range ? char_index + IndexW'(1) : char_index;
        hits_seen  <= hits_next;
        overflowed <= overflowed_next;
      end
    end
  end

  // output queue
  assign n_push = take ? (QCntW'(hit) + QCntW'(s_tlast)) : '0;

  always_ff @(posedge clk) begin
    if (take) begin
      if (hit) begin
        queue[wr_ptr] <= hit_word;
        if (s_tlast) begin
          queue[wr_ptr + QPtrW'(1)] <= sum_word;
        end
      end else if (s_tlast) begin
        queue[wr_ptr] <= sum_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[QPtrW-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      count <= count + n_push - QCntW'(pop);
    end
  end

  assign m_tvalid = (count != '0);
  assign m_tdata  = {queue[rd_ptr].too_long, queue[rd_ptr].limit_reached,
                     queue[rd_ptr].hit_total, queue[rd_ptr].position, queue[rd_ptr].kind};
  assign m_tlast  = queue[rd_ptr].last;

endmodule

`default_nettype wire

// ===== bench/motif_scan_one_mismatch_core_tb.sv =====
`timescale 1ns / 1ps

module motif_scan_one_mismatch_core_tb;
  import msom_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int LongStall  = 300;

  class motif_scoreboard;
    logic [63:0] motif_code;
    logic [5:0]  motif_len;
    logic [3:0]  hit_limit;
    logic [63:0] window;
    int unsigned run_len;
    int unsigned char_pos;
    int unsigned hits;
    bit          overflowed;
    result_t     expected_words[$];
    int          errors;

    function new();
      motif_code = '0;
      motif_len  = 6'd22;
      hit_limit  = 4'd3;
      errors     = 0;
      clear_read();
    endfunction

    function void clear_read();
      window     = '0;
      run_len    = 0;
      char_pos   = 0;
      hits       = 0;
      overflowed = 1'b0;
    endfunction

    function int unsigned eff_len();
      if (motif_len == 0) return 1;
      if (motif_len > MaxMotif) return MaxMotif;
      return motif_len;
    endfunction

    function void set_reg(logic [1:0] idx, logic [63:0] value);
      case (idx)
        REG_MOTIF_CODE: motif_code = value;
        REG_MOTIF_LEN:  motif_len = value[5:0];
        REG_HIT_LIMIT:  hit_limit = value[3:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // one accepted read character: window shift, compare, summary on end of read
    function void scan_char(logic [7:0] ch, logic eor);
      int unsigned len;
      int unsigned lim;
      int unsigned idx;
      bit          in_range;
      bit          is_base;
      logic [1:0]  code;
      logic [63:0] mask;
      logic [63:0] diff;
      int          miss;
      result_t     w;
      len      = eff_len();
      lim      = (hit_limit == 0) ? 1 : hit_limit;
      idx      = char_pos;
      in_range = idx < ReadLenMax;
      is_base  = 1'b1;
      code     = 2'd0;
      case (ch)
        "A", "a": code = 2'd0;
        "C", "c": code = 2'd1;
        "G", "g": code = 2'd2;
        "T", "t": code = 2'd3;
        default: is_base = 1'b0;
      endcase
      if (!in_range) overflowed = 1'b1;
      else char_pos = idx + 1;
      if (!is_base) begin
        window  = '0;
        run_len = 0;
      end else begin
        window = {window[61:0], code};
        if (run_len < MaxMotif) run_len++;
        if (run_len >= len && in_range && hits < lim) begin
          mask = (len >= 32) ? '1 : ((64'd1 << (2 * len)) - 64'd1);
          diff = (window ^ motif_code) & mask;
          miss = 0;
          for (int i = 0; i < 32; i++) if (diff[2*i +: 2] != 2'b00) miss++;
          if (miss <= 1) begin
            w               = '0;
            w.kind          = (miss == 0) ? KIND_EXACT : KIND_ONE_MISS;
            w.position      = PosW'(idx - (len - 1));
            w.last          = !eor;
            expected_words.push_back(w);
            hits++;
          end
        end
      end
      if (eor) begin
        w               = '0;
        w.kind          = KIND_SUMMARY;
        w.hit_total     = hits[3:0];
        w.limit_reached = hits >= lim;
        w.too_long      = overflowed;
        w.last          = 1'b1;
        expected_words.push_back(w);
        clear_read();
      end
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_word(result_t got);
      result_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected output word %h", got));
        return;
      end
      want = expected_words.pop_front();
      if (got.kind != want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.position != want.position)
        report($sformatf("position %0d, want %0d", got.position, want.position));
      if (got.hit_total != want.hit_total)
        report($sformatf("hit_total %0d, want %0d", got.hit_total, want.hit_total));
      if (got.limit_reached != want.limit_reached)
        report($sformatf("limit_reached %0b, want %0b", got.limit_reached,
                         want.limit_reached));
      if (got.too_long != want.too_long)
        report($sformatf("too_long %0b, want %0b", got.too_long, want.too_long));
      if (got.last != want.last)
        report($sformatf("last %0b, want %0b", got.last, want.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // base_char
  logic        s_tlast;   // end_of_read
  logic        m_tvalid;
  logic        m_tready;
  logic [OutDataW-1:0] m_tdata;  // kind, position, hit_total, limit_reached, too_long
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  motif_scoreboard sb;
  int          send_idle_pct = 22;
  int          recv_idle_pct = 84;
  int          stall_asks = 0;
  int          stall_seen = 0;
  int          stall_left = 0;
  int          chars_sent = 0;
  int          cycle_count = 0;

  motif_scan_one_mismatch_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("motif_scan_one_mismatch_core verification failed");
      $finish;
    end
  end

  // receiver: random backpressure, or a long hold when asked
  always @(negedge clk) begin
    if (stall_asks != stall_seen) begin
      stall_seen = stall_asks;
      stall_left = LongStall;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.scan_char(s_tdata, s_tlast);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(result_t'({m_tlast, m_tdata}));
  end

  function automatic logic [7:0] base_char_of(logic [1:0] code, bit lower);
    logic [7:0] ch;
    case (code)
      2'd0: ch = "A";
      2'd1: ch = "C";
      2'd2: ch = "G";
      default: ch = "T";
    endcase
    return lower ? (ch | 8'h20) : ch;
  endfunction

  task automatic send_char(logic [7:0] ch, logic eor);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= eor;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // stop offering, wait for every expected word, then let the pipe settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // motif copies with up to two changed bases, random bases, and noise
  task automatic send_read(int n, bit close);
    logic [7:0]  chars[$];
    int unsigned len;
    int          r;
    int          muts;
    int          p1;
    int          p2;
    logic [1:0]  code;
    len = sb.eff_len();
    while (chars.size() < n) begin
      r = $urandom_range(99);
      if (r < 35) begin
        chars.push_back(base_char_of(2'($urandom_range(3)), 1'($urandom_range(1))));
      end else if (r < 80) begin
        muts = $urandom_range(2);
        p1   = $urandom_range(len - 1);
        p2   = $urandom_range(len - 1);
        for (int i = 0; i < len; i++) begin
          code = sb.motif_code[2*(len-1-i) +: 2];
          if ((muts > 0 && i == p1) || (muts > 1 && i == p2))
            code = code ^ 2'($urandom_range(1, 3));
          chars.push_back(base_char_of(code, 1'($urandom_range(1))));
        end
      end else begin
        chars.push_back(8'($urandom_range(255)));
      end
    end
    foreach (chars[i]) send_char(chars[i], close && (i == chars.size() - 1));
  endtask

  task automatic run_phase(logic [63:0] code, logic [5:0] len, logic [3:0] lim,
                           int n_items, int s_pct, int r_pct, bit pressure);
    int start;
    bit stalled;
    bit paused;
    write_reg(REG_MOTIF_CODE, code);
    write_reg(REG_MOTIF_LEN, {58'd0, len});
    write_reg(REG_HIT_LIMIT, {60'd0, lim});
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    start   = chars_sent;
    stalled = 1'b0;
    paused  = 1'b0;
    while (chars_sent - start < n_items) begin
      if (pressure && !stalled && chars_sent - start > n_items / 3) begin
        stall_asks++;
        stalled = 1'b1;
      end
      if (pressure && !paused && chars_sent - start > 2 * n_items / 3) begin
        drain();
        paused = 1'b1;
      end
      send_read($urandom_range(1, 40), 1'b1);
    end
    // leave the read open so the next settings apply mid-read
    send_read($urandom_range(4, 12), 1'b0);
    drain();
  endtask

  initial begin
    sb       = new();
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    m_tready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: all-a motif of 22 bases, one mismatch at the end
    repeat (21) send_char("A", 1'b0);
    send_char("c", 1'b1);
    drain();
    // zero length and zero limit act as one
    write_reg(REG_MOTIF_LEN, 64'd0);
    write_reg(REG_HIT_LIMIT, 64'd0);
    write_reg(REG_MOTIF_CODE, 64'd2);
    send_char(8'h00, 1'b0);
    send_char("g", 1'b0);
    send_char("G", 1'b0);
    send_char(8'hFF, 1'b1);
    drain();

    run_phase({$urandom, $urandom}, 6'd3, 4'd15, 300, 22, 84, 1'b0);
    run_phase({$urandom, $urandom}, 6'd32, 4'd1, 200, 22, 84, 1'b0);
    run_phase(64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 4'd0, 200, 84, 22, 1'b0);
    run_phase(64'd0, 6'd1, 4'd7, 250, 84, 22, 1'b0);
    run_phase({$urandom, $urandom}, 6'd8, 4'd4, 300, 0, 0, 1'b1);
    run_phase({$urandom, $urandom}, 6'd2, 4'd15, 200, 0, 0, 1'b0);

    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("motif_scan_one_mismatch_core verification clean");
    end else begin
      $display("motif_scan_one_mismatch_core verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/msom_pkg.sv
rtl/core/motif_scan_one_mismatch_core.sv
bench/motif_scan_one_mismatch_core_tb.sv
